// ===== rtl/wrc_pkg.sv =====
package wrc_pkg;

    localparam int SCORE_W   = 16;
    localparam int ANN_W     = 8;
    localparam int RND_W     = 31;
    localparam int IDX_OUT_W = 6;
    localparam int WEIGHT_MAX = 32767;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_CHOOSE = 1'b1;

    // annotation codes that weigh zero while flagged candidates are skipped
    localparam logic [ANN_W-1:0] ANN_BAD_SINGLE = 8'd2;
    localparam logic [ANN_W-1:0] ANN_BAD_LO     = 8'd4;
    localparam logic [ANN_W-1:0] ANN_BAD_END    = 8'd7;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SRCH = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    function automatic logic is_bad_annotation(input logic [ANN_W-1:0] code);
        return (code == ANN_BAD_SINGLE) || ((code >= ANN_BAD_LO) && (code < ANN_BAD_END));
    endfunction

endpackage

// ===== rtl/wrc_cell.sv =====
module wrc_cell #(
    parameter int SW = 21
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic          i_shift,
    input  logic [SW-1:0] i_load_data,
    input  logic [SW-1:0] i_next,
    output logic [SW-1:0] o_value
);

    logic [SW-1:0] r_value;
    logic [SW-1:0] n_value;

    always_comb begin
        priority if (i_load) begin
            n_value = i_load_data;
        end else if (i_shift) begin
            // advance toward the head of the chain
            n_value = i_next;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/wrc_mod.sv =====
module wrc_mod #(
    parameter int SW = 21
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wrc_pkg::RND_W-1:0] i_dividend,
    input  logic [SW-1:0]             i_divisor,
    output logic                      o_done,
    output logic [SW-1:0]             o_rem
);
    import wrc_pkg::*;

    localparam int CNT_W = $clog2(RND_W);

    logic             r_busy;
    logic             n_busy;
    logic             r_done;
    logic             n_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [RND_W-1:0] r_dvd;
    logic [RND_W-1:0] n_dvd;
    logic [SW-1:0]    r_rem;
    logic [SW-1:0]    n_rem;
    logic [SW:0]      trial;
    logic [SW:0]      diff;

    always_comb begin
        trial   = {r_rem, r_dvd[RND_W-1]};
        diff    = trial - {1'b0, i_divisor};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        priority if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(RND_W - 1);
            n_dvd  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            // restoring step: one dividend bit per cycle
            n_dvd = {r_dvd[RND_W-2:0], 1'b0};
            n_rem = (trial >= {1'b0, i_divisor}) ? diff[SW-1:0] : trial[SW-1:0];
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CNT_W'(1);
            end
        end else begin
            // hold the remainder for the search
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/weighted_random_choice_unit.sv =====
// Weighted random choice over up to MAX_ENTRIES candidates. An append word
// (func 0) turns its score into a weight (negative scores, and with the
// skip-flagged bit set annotations 2, 4, 5 and 6, weigh zero) and stores the
// running sum in the next cell of a chain; appends past capacity are dropped.
// A choose word (func 1) reduces random_value modulo the total in a bit-serial
// divider, then shifts the chain toward its head one cell per cycle, comparing
// the head against the remainder, so the search walks the candidates in order
// up to the chosen one. An empty list answers found 0 and a zero total answers
// found 1 with index 0, both with no divide. Each choose gives one result word
// and clears the list. No input is taken while a choose is in flight.
module weighted_random_choice_unit #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic signed [wrc_pkg::SCORE_W-1:0] i_candidate_score,
    input  logic [wrc_pkg::ANN_W-1:0]     i_annotation,
    input  logic [wrc_pkg::RND_W-1:0]     i_random_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [wrc_pkg::IDX_OUT_W-1:0] o_chosen_index
);
    import wrc_pkg::*;

    localparam int SW = $clog2(MAX_ENTRIES * WEIGHT_MAX + 1);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);

    t_state          r_state;
    t_state          n_state;
    logic            r_skip_flagged;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [SW-1:0]   r_total;
    logic [SW-1:0]   n_total;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   n_idx;
    logic            r_res_found;
    logic            n_res_found;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            r_out_found;
    logic            n_out_found;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic [IDX_OUT_W-1:0] n_out_idx;

    logic            in_acc;
    logic            append_en;
    logic            div_start;
    logic            div_done;
    logic [SW-1:0]   div_rem;
    logic            chain_shift;
    logic            hit;
    logic [SW-1:0]   weight;
    logic [IW+IDX_OUT_W-1:0] idx_ext;
    logic [SW-1:0]   cell_val [MAX_ENTRIES];

    assign in_acc = i_in_valid && !o_in_stall;
    assign hit    = div_rem < cell_val[0];
    assign idx_ext = {{IDX_OUT_W{1'b0}}, r_idx};

    always_comb begin
        weight = i_candidate_score[SCORE_W-1] ? '0
               : {{(SW-SCORE_W+1){1'b0}}, i_candidate_score[SCORE_W-2:0]};
        if (r_skip_flagged && is_bad_annotation(i_annotation)) begin
            weight = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_idx       = r_idx;
        n_res_found = r_res_found;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_idx   = r_out_idx;
        append_en   = 1'b0;
        div_start   = 1'b0;
        chain_shift = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_func == FUNC_APPEND) begin
                        if (r_count < CW'(MAX_ENTRIES)) begin
                            append_en = 1'b1;
                            n_total   = r_total + weight;
                            n_count   = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_res_found = 1'b0;
                        n_idx       = '0;
                        n_state     = S_OUT;
                    end else if (r_total == '0) begin
                        n_res_found = 1'b1;
                        n_idx       = '0;
                        n_state     = S_OUT;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_idx   = '0;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                // the last sum equals the total, so a hit comes by the last entry
                if (hit || ((CW'(r_idx) + CW'(1)) == r_count)) begin
                    n_res_found = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    n_idx       = r_idx + IW'(1);
                    chain_shift = 1'b1;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_idx   = idx_ext[IDX_OUT_W-1:0];
                    n_count     = '0;
                    n_total     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_skip_flagged <= 1'b0;
            r_count        <= '0;
            r_total        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_skip_flagged <= i_cfg_wr_data;
            end
        end
        r_idx       <= n_idx;
        r_res_found <= n_res_found;
        r_out_found <= n_out_found;
        r_out_idx   <= n_out_idx;
    end

    wrc_mod #(
        .SW(SW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_random_value),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        logic [SW-1:0] next_val;
        if (gi == MAX_ENTRIES - 1) begin : g_tail
            assign next_val = '0;
        end else begin : g_body
            assign next_val = cell_val[gi+1];
        end
        wrc_cell #(
            .SW(SW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_load      (append_en && (r_count == CW'(gi))),
            .i_shift     (chain_shift),
            .i_load_data (n_total),
            .i_next      (next_val),
            .o_value     (cell_val[gi])
        );
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_chosen_index = r_out_idx;

endmodule

// ===== sim/wrc_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the weighted random
// choice unit, keeps its own copy of the candidate list and flags every
// result word that differs from the predicted pick.
module wrc_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_wr_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic                                i_func,
    input  logic signed [wrc_pkg::SCORE_W-1:0]  i_candidate_score,
    input  logic [wrc_pkg::ANN_W-1:0]           i_annotation,
    input  logic [wrc_pkg::RND_W-1:0]           i_random_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic                                i_found,
    input  logic [wrc_pkg::IDX_OUT_W-1:0]       i_chosen_index,
    output int                                  o_mismatches,
    output int                                  o_waiting
);
    import wrc_pkg::*;

    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] index;
    } t_pick;

    t_pick       picks_due[$];
    logic [31:0] running_sums [CAPACITY];
    logic [31:0] wheel_total;
    int          held;
    logic        skip_flagged;

    initial begin
        o_mismatches = 0;
        o_waiting    = 0;
        held         = 0;
        wheel_total  = '0;
        skip_flagged = 1'b0;
    end

    // Apply one accepted input word to the predicted candidate list.
    task automatic spin_wheel(input logic func, input logic signed [SCORE_W-1:0] score,
                              input logic [ANN_W-1:0] ann, input logic [RND_W-1:0] draw);
        logic [31:0] weight;
        logic [31:0] slot;
        t_pick       pick;
        if (func == FUNC_APPEND) begin
            if (held < CAPACITY) begin
                weight = score[SCORE_W-1] ? 32'd0 : {{(32-SCORE_W){1'b0}}, score};
                if (skip_flagged && (ann == ANN_BAD_SINGLE
                                     || (ann >= ANN_BAD_LO && ann < ANN_BAD_END)))
                    weight = 32'd0;
                wheel_total        = wheel_total + weight;
                running_sums[held] = wheel_total;
                held               = held + 1;
            end
        end else begin
            pick = '0;
            if (held != 0) begin
                pick.found = 1'b1;
                if (wheel_total != 0) begin
                    slot = {1'b0, draw} % wheel_total;
                    // walk down so the lowest matching position wins
                    for (int i = held - 1; i >= 0; i--)
                        if (slot < running_sums[i])
                            pick.index = i[IDX_OUT_W-1:0];
                end
                held        = 0;
                wheel_total = '0;
            end
            picks_due.push_back(pick);
        end
    endtask

    always @(posedge i_clk) begin
        t_pick want;
        if (!i_rst_n) begin
            held         = 0;
            wheel_total  = '0;
            skip_flagged = 1'b0;
            picks_due.delete();
        end else begin
            if (i_cfg_wr_en)
                skip_flagged = i_cfg_wr_data;
            // compare before taking input: a choose cannot answer in its own cycle
            if (i_out_valid && !i_out_stall) begin
                if (picks_due.size() == 0) begin
                    $error("result word with no choose pending: found %0d index %0d",
                           i_found, i_chosen_index);
                    o_mismatches++;
                end else begin
                    want = picks_due.pop_front();
                    if (i_found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, i_found);
                        o_mismatches++;
                    end
                    if (i_chosen_index !== want.index) begin
                        $error("chosen_index: expected %0d, actual %0d",
                               want.index, i_chosen_index);
                        o_mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                spin_wheel(i_func, i_candidate_score, i_annotation, i_random_value);
        end
        o_waiting = picks_due.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import wrc_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int PHASE_WORDS    = 360;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_wr_en;
    logic                         i_cfg_wr_data;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic                         i_func;
    logic signed [SCORE_W-1:0]    i_candidate_score;
    logic [ANN_W-1:0]             i_annotation;
    logic [RND_W-1:0]             i_random_value;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic                         o_found;
    logic [IDX_OUT_W-1:0]         o_chosen_index;

    int mismatches;
    int waiting;
    int words_sent;
    int src_idle;
    int snk_idle;
    int quiet_cycles;

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = 1'b0;
        i_in_valid        = 1'b0;
        i_func            = FUNC_APPEND;
        i_candidate_score = '0;
        i_annotation      = '0;
        i_random_value    = '0;
        i_out_stall       = 1'b0;
        words_sent        = 0;
        src_idle          = 19;
        snk_idle          = 19;
        quiet_cycles      = 0;
    end

    always #5 i_clk = ~i_clk;

    weighted_random_choice_unit #(
        .MAX_ENTRIES(CAPACITY)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_candidate_score (i_candidate_score),
        .i_annotation      (i_annotation),
        .i_random_value    (i_random_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_found           (o_found),
        .o_chosen_index    (o_chosen_index)
    );

    wrc_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_candidate_score (i_candidate_score),
        .i_annotation      (i_annotation),
        .i_random_value    (i_random_value),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_found           (o_found),
        .i_chosen_index    (o_chosen_index),
        .o_mismatches      (mismatches),
        .o_waiting         (waiting)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < snk_idle);
    end

    // Abort when neither channel has moved a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one word, after a random gap, and hold it until accepted.
    task automatic send_word(input logic func, input logic signed [SCORE_W-1:0] score,
                             input logic [ANN_W-1:0] ann, input logic [RND_W-1:0] draw);
        while ($urandom_range(99) < src_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_func            <= func;
        i_candidate_score <= score;
        i_annotation      <= ann;
        i_random_value    <= draw;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0)
            @(posedge i_clk);
    endtask

    task automatic write_skip_flagged(input logic value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Load a random list of candidates and spin the wheel once, at times twice.
    task automatic load_and_choose();
        int                        roll;
        int                        count;
        logic signed [SCORE_W-1:0] score;
        logic [ANN_W-1:0]          ann;
        logic [RND_W-1:0]          draw;
        roll = $urandom_range(99);
        if (roll < 70)
            count = $urandom_range(8, 1);
        else if (roll < 88)
            count = $urandom_range(40, 9);
        else if (roll < 96)
            count = $urandom_range(CAPACITY, 41);
        else
            count = $urandom_range(CAPACITY + 6, CAPACITY);
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 50)
                score = SCORE_W'($urandom);
            else if (roll < 80)
                score = SCORE_W'($urandom_range(200));
            else if (roll < 85)
                score = 16'sh7FFF;
            else if (roll < 90)
                score = 16'sh8000;
            else
                score = '0;
            ann = ($urandom_range(99) < 60) ? ANN_W'($urandom_range(8)) : ANN_W'($urandom);
            send_word(FUNC_APPEND, score, ann, RND_W'($urandom));
        end
        roll = $urandom_range(99);
        if (roll < 25)
            draw = RND_W'($urandom_range(300));
        else if (roll < 37)
            draw = 31'h7FFF_FFFF;
        else
            draw = RND_W'($urandom);
        send_word(FUNC_CHOOSE, SCORE_W'($urandom), ANN_W'($urandom), draw);
        // noise: spin again on the now empty list
        if ($urandom_range(99) < 8)
            send_word(FUNC_CHOOSE, SCORE_W'($urandom), ANN_W'($urandom), RND_W'($urandom));
    endtask

    initial begin
        int target;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_skip_flagged(1'b0);

        // empty list
        send_word(FUNC_CHOOSE, SCORE_W'($urandom), ANN_W'($urandom), RND_W'($urandom));
        // score extremes, flagged annotations count while skipping is off
        send_word(FUNC_APPEND, 16'sh7FFF, ANN_BAD_SINGLE, RND_W'($urandom));
        send_word(FUNC_APPEND, 16'sh8000, 8'd0, RND_W'($urandom));
        send_word(FUNC_APPEND, 16'sh0000, 8'hFF, RND_W'($urandom));
        send_word(FUNC_APPEND, 16'shFFFF, ANN_BAD_LO, RND_W'($urandom));
        send_word(FUNC_APPEND, 16'sh0001, 8'd6, RND_W'($urandom));
        send_word(FUNC_CHOOSE, SCORE_W'($urandom), ANN_W'($urandom), 31'h7FFF_FFFF);
        // all weights zero
        send_word(FUNC_APPEND, -16'sd5, 8'd3, RND_W'($urandom));
        send_word(FUNC_APPEND, 16'sh8000, 8'd1, RND_W'($urandom));
        send_word(FUNC_CHOOSE, SCORE_W'($urandom), ANN_W'($urandom), 31'd12345);

        write_skip_flagged(1'b1);
        send_word(FUNC_APPEND, 16'sh7FFF, ANN_BAD_SINGLE, RND_W'($urandom));
        send_word(FUNC_APPEND, 16'sd100, ANN_BAD_LO, RND_W'($urandom));
        send_word(FUNC_APPEND, 16'sd100, 8'd5, RND_W'($urandom));
        send_word(FUNC_APPEND, 16'sd100, 8'd6, RND_W'($urandom));
        send_word(FUNC_APPEND, 16'sd200, 8'd3, RND_W'($urandom));
        send_word(FUNC_APPEND, 16'sd300, ANN_BAD_END, RND_W'($urandom));
        send_word(FUNC_APPEND, 16'sd400, 8'hFF, RND_W'($urandom));
        send_word(FUNC_APPEND, 16'sd500, 8'd0, RND_W'($urandom));
        send_word(FUNC_CHOOSE, SCORE_W'($urandom), ANN_W'($urandom), 31'h7FFF_FFFF);
        // only a flagged candidate: zero total
        send_word(FUNC_APPEND, 16'sd1000, ANN_BAD_SINGLE, RND_W'($urandom));
        send_word(FUNC_CHOOSE, SCORE_W'($urandom), ANN_W'($urandom), RND_W'($urandom));

        target = words_sent;
        for (int phase = 0; phase < 4; phase++) begin
            // the drain inside the register write holds the sender until all results are in
            write_skip_flagged(1'(phase % 2));
            src_idle = (phase == 1) ? 0 : 19;
            snk_idle = (phase == 1) ? 0 : 19;
            target   = target + PHASE_WORDS;
            while (words_sent < target)
                load_and_choose();
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && waiting == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== weighted_random_choice_unit.f =====
rtl/wrc_pkg.sv
rtl/wrc_cell.sv
rtl/wrc_mod.sv
rtl/weighted_random_choice_unit.sv
sim/wrc_checker.sv
sim/tb.sv
